FILE: hdl/fcfl_pkg.sv
// ----------------------------------------------------------------------------
// fcfl_pkg: shared types and constants of the chunk free-list allocator
// Request, response and queue entry layouts, command and status codes.
// ----------------------------------------------------------------------------
package fcfl_pkg;

  localparam int unsigned CNT_W       = 9;  // pool size register width
  localparam int unsigned IDX_W       = 8;  // chunk index width on the ports
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC    = 2'd0,
    CMD_FREE     = 2'd1,
    CMD_FREE_ALL = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Work handed from the front to the back.
  typedef enum logic [1:0] {
    OP_REPLY    = 2'd0,  // answer with a fixed status, no state change
    OP_ALLOC    = 2'd1,
    OP_PUSH     = 2'd2,
    OP_FREE_ALL = 2'd3
  } op_e;

  typedef logic [CNT_W-1:0] cfg_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] chunk_index;
    logic             is_null;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0] granted_index;
    logic [1:0]       status;
  } rsp_t;

  typedef struct packed {
    op_e              op;
    status_e          status;
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

FILE: hdl/fcfl_chan_if.sv
// ----------------------------------------------------------------------------
// fcfl_chan_if: valid/ready channel
// Carries one payload of the given type per request.
// ----------------------------------------------------------------------------
interface fcfl_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/fcfl_ram.sv
// ----------------------------------------------------------------------------
// fcfl_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module fcfl_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hdl/fcfl_front.sv
// ----------------------------------------------------------------------------
// fcfl_front: request intake and classification
// Holds the pool size register, checks free requests against the pool size
// and turns each request into a queue entry for the back end.
// ----------------------------------------------------------------------------
module fcfl_front #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  fcfl_chan_if.sink        req_i,
  fcfl_chan_if.sink        cfg_i,
  input  logic             q_full_i,
  output logic             q_push_o,
  output fcfl_pkg::entry_t q_data_o
);
  import fcfl_pkg::*;

  // Largest pool size the count register can express at this depth.
  localparam int unsigned CAP = (MAX_CHUNKS < (1 << CNT_W)) ? MAX_CHUNKS : (1 << CNT_W) - 1;

  logic [CNT_W-1:0] count_q;
  logic [CNT_W-1:0] eff_count;
  entry_t           entry;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_i.valid) begin
      count_q <= cfg_i.data;
    end
  end

  assign eff_count = (count_q > CNT_W'(CAP)) ? CNT_W'(CAP) : count_q;

  always_comb begin
    entry = '{op: OP_REPLY, status: ST_OK, idx: req_i.data.chunk_index, cnt: eff_count};
    unique case (req_i.data.cmd)
      CMD_ALLOC: begin
        entry.op = OP_ALLOC;
      end
      CMD_FREE: begin
        priority if (req_i.data.is_null) begin
          entry.op = OP_REPLY;
        end else if (CNT_W'(req_i.data.chunk_index) >= eff_count) begin
          entry.status = ST_RANGE;
        end else begin
          entry.op = OP_PUSH;
        end
      end
      CMD_FREE_ALL: begin
        entry.op = OP_FREE_ALL;
      end
      default: begin
        entry.op = OP_REPLY;  // unused command: plain ok
      end
    endcase
  end

  assign req_i.ready = !q_full_i;
  assign q_push_o    = req_i.valid && !q_full_i;
  assign q_data_o    = entry;

endmodule

FILE: hdl/fcfl_queue.sv
// ----------------------------------------------------------------------------
// fcfl_queue: short FIFO between front and back
// Lets the intake keep taking requests while the back end is busy.
// ----------------------------------------------------------------------------
module fcfl_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  fcfl_pkg::entry_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output fcfl_pkg::entry_t data_o,
  output logic             empty_o
);
  import fcfl_pkg::*;

  localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  entry_t        slot_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q;
  logic [PW-1:0] rd_q;
  logic [PW:0]   fill_q;

  assign full_o  = (fill_q == (PW + 1)'(QUEUE_DEPTH));
  assign empty_o = (fill_q == '0);
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

FILE: hdl/fcfl_back.sv
// ----------------------------------------------------------------------------
// fcfl_back: free-list engine
// Owns the head register and the link memory; pops, pushes and rebuilds the
// list and holds the response register.
// ----------------------------------------------------------------------------
module fcfl_back #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  fcfl_pkg::entry_t q_data_i,
  output logic             q_pop_o,
  fcfl_chan_if.source      rsp_o
);
  import fcfl_pkg::*;

  localparam int unsigned IW = $clog2(MAX_CHUNKS);
  localparam int unsigned LW = $clog2(MAX_CHUNKS + 1);
  localparam logic [LW-1:0] NULL_LINK = LW'(MAX_CHUNKS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_ALLOC = 2'd1;  // waiting for the head's link
  localparam logic [1:0] S_SWEEP = 2'd2;  // rebuilding the list

  logic [1:0]       state_q, state_d;
  logic [LW-1:0]    head_q, head_d;
  logic             out_valid_q, out_valid_d;
  rsp_t             out_q, out_d;
  logic [IDX_W-1:0] gnt_q, gnt_d;
  logic [CNT_W-1:0] sweep_q, sweep_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic             out_free;
  logic             ram_we;
  logic [IW-1:0]    ram_waddr;
  logic [LW-1:0]    ram_wdata;
  logic [IW-1:0]    ram_raddr;
  logic [LW-1:0]    ram_rdata;

  fcfl_ram #(
    .WIDTH (LW),
    .DEPTH (MAX_CHUNKS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // A new request starts only when its response has somewhere to go.
  assign out_free = !out_valid_q || rsp_o.ready;
  assign q_pop_o  = (state_q == S_IDLE) && !q_empty_i && out_free;

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    gnt_d       = gnt_q;
    sweep_d     = sweep_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_d       = out_q;
    ram_we      = 1'b0;
    ram_waddr   = IW'(q_data_i.idx);
    ram_wdata   = head_q;
    ram_raddr   = IW'(head_q);

    unique case (state_q)
      S_IDLE: begin
        if (q_pop_o) begin
          unique case (q_data_i.op)
            OP_REPLY: begin
              out_valid_d = 1'b1;
              out_d       = '{granted_index: '0, status: q_data_i.status};
            end
            OP_PUSH: begin
              ram_we      = 1'b1;
              head_d      = LW'(q_data_i.idx);
              out_valid_d = 1'b1;
              out_d       = '{granted_index: '0, status: ST_OK};
            end
            OP_ALLOC: begin
              if (head_q == NULL_LINK) begin
                out_valid_d = 1'b1;
                out_d       = '{granted_index: '0, status: ST_EMPTY};
              end else begin
                gnt_d   = IDX_W'(head_q);
                state_d = S_ALLOC;
              end
            end
            OP_FREE_ALL: begin
              if (q_data_i.cnt == '0) begin
                head_d      = NULL_LINK;
                out_valid_d = 1'b1;
                out_d       = '{granted_index: '0, status: ST_OK};
              end else begin
                sweep_d = '0;
                cnt_d   = q_data_i.cnt;
                state_d = S_SWEEP;
              end
            end
          endcase
        end
      end
      S_ALLOC: begin
        head_d      = ram_rdata;
        out_valid_d = 1'b1;
        out_d       = '{granted_index: gnt_q, status: ST_OK};
        state_d     = S_IDLE;
      end
      S_SWEEP: begin
        // chunk i links to i-1, chunk 0 ends the list
        ram_we    = 1'b1;
        ram_waddr = IW'(sweep_q);
        ram_wdata = (sweep_q == '0) ? NULL_LINK : LW'(sweep_q - CNT_W'(1));
        if (sweep_q == cnt_q - CNT_W'(1)) begin
          head_d      = LW'(sweep_q);
          out_valid_d = 1'b1;
          out_d       = '{granted_index: '0, status: ST_OK};
          state_d     = S_IDLE;
        end else begin
          sweep_d = sweep_q + CNT_W'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= NULL_LINK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q   <= out_d;
    gnt_q   <= gnt_d;
    sweep_q <= sweep_d;
    cnt_q   <= cnt_d;
  end

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_q;

  a_alloc_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_ALLOC |-> !out_valid_q)
    else $error("allocate in flight while a response is pending");

  a_pop_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == S_IDLE)
    else $error("queue popped while the engine is busy");

  a_head_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= NULL_LINK)
    else $error("head points past the pool");

  a_sweep_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SWEEP |-> sweep_q < cnt_q)
    else $error("rebuild runs past the chunk count");

endmodule

FILE: hdl/fixed_chunk_free_list_allocator_top.sv
// ----------------------------------------------------------------------------
// fixed_chunk_free_list_allocator_top: LIFO free-list chunk allocator
// Request to response: each request passes through the queue and the response
// register; an allocate adds a registered read of the head's link, and a
// free-all writes one link per cycle while it rebuilds the list.
// Throughput: one free or fixed reply per cycle while the reply channel takes
// them; an allocate or a free-all holds the engine until it has finished.
// Reset: list empty, pool size 0; link memory is not cleared.
// ----------------------------------------------------------------------------
module fixed_chunk_free_list_allocator_top #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fcfl_chan_if.sink   req_i,
  fcfl_chan_if.source rsp_o,
  fcfl_chan_if.sink   cfg_i
);
  import fcfl_pkg::*;

  logic   q_push;
  logic   q_full;
  logic   q_pop;
  logic   q_empty;
  entry_t q_wr_data;
  entry_t q_rd_data;

  fcfl_front #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cfg_i    (cfg_i),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_data_o (q_wr_data)
  );

  fcfl_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_data),
    .empty_o (q_empty)
  );

  fcfl_back #(
    .MAX_CHUNKS (MAX_CHUNKS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_data_i  (q_rd_data),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule

FILE: bench/fcfl_reply_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcfl_reply_checker: reply predictor and scoreboard for the chunk allocator
// Watches the request, reply and pool-size channels and keeps its own copy of
// the free list (per-chunk links, head, pool size). Each reply is compared,
// field by field, with the oldest predicted reply.
// ----------------------------------------------------------------------------
module fcfl_reply_checker #(
  parameter int unsigned MAX_CHUNKS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            req_ready_i,
  input  fcfl_pkg::req_t  req_data_i,
  input  logic            rsp_valid_i,
  input  logic            rsp_ready_i,
  input  fcfl_pkg::rsp_t  rsp_data_i,
  input  logic            cfg_valid_i,
  input  logic            cfg_ready_i,
  input  fcfl_pkg::cfg_t  cfg_data_i,
  output int              err_count_o,
  output int              pending_o,
  output int              checked_o
);
  import fcfl_pkg::*;

  localparam logic [CNT_W-1:0] NULL_LINK = CNT_W'(MAX_CHUNKS);

  logic [CNT_W-1:0] link_mem [MAX_CHUNKS];
  logic [CNT_W-1:0] head_ptr;
  cfg_t             pool_size;
  rsp_t             reply_q [$];
  int               n_bad;
  int               n_seen;

  // Applies one request to the shadow free list and returns the reply it earns.
  function automatic rsp_t next_reply(req_t r);
    int unsigned live;
    rsp_t        rsp;
    live = (pool_size > MAX_CHUNKS) ? MAX_CHUNKS : pool_size;
    rsp  = '0;
    rsp.status = ST_OK;
    case (r.cmd)
      CMD_ALLOC: begin
        if (head_ptr >= NULL_LINK) begin
          rsp.status = ST_EMPTY;
        end else begin
          rsp.granted_index = head_ptr[IDX_W-1:0];
          head_ptr = link_mem[head_ptr];
        end
      end
      CMD_FREE: begin
        if (!r.is_null) begin
          if (r.chunk_index >= live) begin
            rsp.status = ST_RANGE;
          end else begin
            link_mem[r.chunk_index] = head_ptr;
            head_ptr = CNT_W'(r.chunk_index);
          end
        end
      end
      CMD_FREE_ALL: begin
        // rebuilt so that the highest chunk pops first
        head_ptr = NULL_LINK;
        for (int unsigned i = 0; i < live; i++) begin
          link_mem[i] = head_ptr;
          head_ptr = CNT_W'(i);
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      head_ptr  = NULL_LINK;
      pool_size = '0;
      reply_q.delete();
      n_bad  = 0;
      n_seen = 0;
    end else begin
      // replies first: the matching request was accepted on an earlier edge
      if (rsp_valid_i && rsp_ready_i) begin
        if (reply_q.size() == 0) begin
          $error("reply with none outstanding: granted_index %0d, status %0d",
                 rsp_data_i.granted_index, rsp_data_i.status);
          n_bad++;
        end else begin
          want = reply_q.pop_front();
          n_seen++;
          if (rsp_data_i.granted_index !== want.granted_index) begin
            $error("granted_index: expected %0d, got %0d",
                   want.granted_index, rsp_data_i.granted_index);
            n_bad++;
          end
          if (rsp_data_i.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_data_i.status);
            n_bad++;
          end
        end
      end
      if (req_valid_i && req_ready_i) reply_q.push_back(next_reply(req_data_i));
      if (cfg_valid_i && cfg_ready_i) pool_size = cfg_data_i;
    end
    err_count_o <= n_bad;
    checked_o   <= n_seen;
    pending_o   <= reply_q.size();
  end

endmodule

FILE: bench/tb_fixed_chunk_free_list_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fixed_chunk_free_list_allocator_top: free-list allocator testbench
// Directed corner requests, then phases of random allocate/free traffic over
// a range of pool sizes and back-pressure patterns; replies are scored by
// fcfl_reply_checker.
// ----------------------------------------------------------------------------
module tb_fixed_chunk_free_list_allocator_top;
  import fcfl_pkg::*;

  localparam int unsigned MAX_CHUNKS  = 256;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = MAX_CHUNKS + 16;
  localparam int unsigned N_PHASES    = 12;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;

  logic clk;
  logic rst_n;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   sent      = 0;
  int   cfg_writes = 0;
  int   quiet     = 0;
  int   mism;
  int   pending;
  int   checked;

  fcfl_chan_if #(.payload_t(req_t)) req_if ();
  fcfl_chan_if #(.payload_t(rsp_t)) rsp_if ();
  fcfl_chan_if #(.payload_t(cfg_t)) cfg_if ();

  fixed_chunk_free_list_allocator_top #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if),
    .cfg_i (cfg_if)
  );

  fcfl_reply_checker #(
    .MAX_CHUNKS(MAX_CHUNKS)
  ) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_data_i (req_if.data),
    .rsp_valid_i(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready),
    .rsp_data_i (rsp_if.data),
    .cfg_valid_i(cfg_if.valid),
    .cfg_ready_i(cfg_if.ready),
    .cfg_data_i (cfg_if.data),
    .err_count_o(mism),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // reply side back-pressure
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // nothing accepted on any channel for too long: give up
  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet <= 0;
      end else if (quiet + 1 >= QUIET_LIMIT) begin
        $display("tb_fixed_chunk_free_list_allocator_top: done, errors");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  task automatic set_idle(int mode);
    case (mode)
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 68; stall_pct = 0;  end
      2: begin gap_pct = 0;  stall_pct = 68; end
      default: begin gap_pct = 9; stall_pct = 9; end
    endcase
  endtask

  task automatic send_req(logic [1:0] cmd, logic [IDX_W-1:0] idx, logic nul);
    int gap;
    gap = 0;
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) gap++;
    if (gap != 0) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_if.valid <= 1'b1;
    req_if.data  <= req_t'{cmd: cmd, chunk_index: idx, is_null: nul};
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    sent++;
  endtask

  task automatic drop_req_valid();
    if (req_if.valid) begin
      @(negedge clk);
      req_if.valid <= 1'b0;
    end
  endtask

  // pool size only changes with nothing in flight
  task automatic write_count(cfg_t size);
    drop_req_valid();
    while (pending != 0) @(negedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= size;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
    cfg_writes++;
  endtask

  task automatic random_item(int unsigned live);
    int               roll;
    logic [IDX_W-1:0] idx;
    logic             nul;
    roll = $urandom_range(99);
    idx  = IDX_W'($urandom);
    nul  = 1'($urandom);
    if (roll < 46) begin
      send_req(CMD_ALLOC, idx, nul);
    end else if (roll < 92) begin
      nul = ($urandom_range(99) < 8);
      if (live != 0 && $urandom_range(99) < 85) idx = IDX_W'($urandom_range(live - 1));
      send_req(CMD_FREE, idx, nul);
    end else if (roll < 96) begin
      send_req(CMD_FREE_ALL, idx, nul);
    end else begin
      send_req(CMD_UNUSED, idx, nul);
    end
  endtask

  initial begin
    cfg_t        sizes [N_PHASES];
    int unsigned live;
    rst_n        = 1'b0;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    sizes = '{9'd1, 9'd5, 9'd256, 9'd8, 9'd2, 9'd0, 9'd16, 9'd255, 9'd3, 9'd4, 9'd6, 9'd7};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    set_idle(0);

    // pool size 0 straight out of reset
    send_req(CMD_ALLOC, 8'h00, 1'b0);
    send_req(CMD_FREE, 8'h00, 1'b0);
    send_req(CMD_FREE_ALL, 8'hFF, 1'b0);
    send_req(CMD_ALLOC, 8'hFF, 1'b1);

    write_count(9'd3);
    send_req(CMD_FREE_ALL, 8'h00, 1'b1);
    send_req(CMD_ALLOC, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 8'hAA, 1'b1);
    send_req(CMD_ALLOC, 8'h55, 1'b0);
    send_req(CMD_ALLOC, 8'h00, 1'b0);  // drained
    send_req(CMD_FREE, 8'hFF, 1'b0);
    send_req(CMD_FREE, 8'd3, 1'b0);    // one past the end
    send_req(CMD_FREE, 8'd1, 1'b1);    // null, ignored
    send_req(CMD_FREE, 8'd1, 1'b0);
    send_req(CMD_FREE, 8'd1, 1'b0);    // double free goes through
    send_req(CMD_UNUSED, 8'hFF, 1'b1);
    send_req(CMD_ALLOC, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 8'h00, 1'b0);

    // oversize register clamps to the full pool
    write_count(9'd511);
    send_req(CMD_FREE_ALL, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 8'h00, 1'b0);

    // shrink without a rebuild: stale chunks still come out
    write_count(9'd1);
    send_req(CMD_ALLOC, 8'h00, 1'b0);
    send_req(CMD_FREE, 8'hFF, 1'b0);
    send_req(CMD_FREE, 8'h00, 1'b0);
    send_req(CMD_ALLOC, 8'h00, 1'b0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      if (ph == 10) sizes[ph] = CNT_W'($urandom_range(40, 2));
      if (ph == 11) sizes[ph] = CNT_W'($urandom_range(511, 0));
      write_count(sizes[ph]);
      set_idle(ph % 4);
      live = (sizes[ph] > MAX_CHUNKS) ? MAX_CHUNKS : sizes[ph];
      send_req(CMD_FREE_ALL, IDX_W'($urandom), 1'($urandom));
      repeat (47) random_item(live);
    end

    drop_req_valid();
    while (pending != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("%0d requests sent across %0d pool-size writes (sizes 0 to 511)",
             sent, cfg_writes);
    $display("%0d replies checked under four idle/stall patterns", checked);
    if (mism == 0) begin
      $display("tb_fixed_chunk_free_list_allocator_top: done, clean");
    end else begin
      $display("tb_fixed_chunk_free_list_allocator_top: done, errors");
    end
    $finish;
  end

endmodule
